### rtl/core/itrn_pkg.sv
// Package: shared types, letter codes and digit-pattern functions for the Roman numeral converter
`default_nettype none

package itrn_pkg;

  localparam int ValueWidth  = 12;
  localparam int DigitWidth  = 4;
  localparam int SymbolWidth = 8;
  localparam int ThrWidth    = 14;

  // Decimal places, most significant first
  localparam logic [1:0] PLACE_THOUSANDS = 2'd3;
  localparam logic [1:0] PLACE_HUNDREDS  = 2'd2;
  localparam logic [1:0] PLACE_TENS      = 2'd1;
  localparam logic [1:0] PLACE_ONES      = 2'd0;

  localparam logic [SymbolWidth-1:0] CHAR_I = 8'h49;
  localparam logic [SymbolWidth-1:0] CHAR_V = 8'h56;
  localparam logic [SymbolWidth-1:0] CHAR_X = 8'h58;
  localparam logic [SymbolWidth-1:0] CHAR_L = 8'h4C;
  localparam logic [SymbolWidth-1:0] CHAR_C = 8'h43;
  localparam logic [SymbolWidth-1:0] CHAR_D = 8'h44;
  localparam logic [SymbolWidth-1:0] CHAR_M = 8'h4D;

  typedef enum logic [1:0] {
    KIND_UNIT,
    KIND_FIVE,
    KIND_TEN
  } letter_kind_e;

  typedef struct packed {
    logic       load;
    logic       split;
    logic       emit;
    logic [1:0] place;
    logic [1:0] pos;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] len;
    logic       tail_zero;
  } dp_status_t;

  // k times the weight of a place
  function automatic logic [ThrWidth-1:0] place_threshold(logic [1:0] place,
                                                          logic [DigitWidth-1:0] k);
    logic [ThrWidth-1:0] kx;
    logic [ThrWidth-1:0] res;
    kx = ThrWidth'(k);
    unique case (place)
      PLACE_THOUSANDS: res = kx * 14'd1000;
      PLACE_HUNDREDS:  res = kx * 14'd100;
      PLACE_TENS:      res = kx * 14'd10;
      default:         res = kx;
    endcase
    return res;
  endfunction

  // Number of letters a digit produces
  function automatic logic [2:0] digit_len(logic [DigitWidth-1:0] d);
    logic [2:0] res;
    case (d)
      4'd4, 4'd9: res = 3'd2;
      4'd5:       res = 3'd1;
      4'd6:       res = 3'd2;
      4'd7:       res = 3'd3;
      4'd8:       res = 3'd4;
      4'd1:       res = 3'd1;
      4'd2:       res = 3'd2;
      4'd3:       res = 3'd3;
      default:    res = 3'd0;
    endcase
    return res;
  endfunction

  // Which letter of the place stands at position pos of digit d
  function automatic letter_kind_e digit_kind(logic [DigitWidth-1:0] d, logic [1:0] pos);
    letter_kind_e res;
    res = KIND_UNIT;
    if (d == 4'd9) begin
      res = (pos == 2'd0) ? KIND_UNIT : KIND_TEN;
    end else if (d == 4'd4) begin
      res = (pos == 2'd0) ? KIND_UNIT : KIND_FIVE;
    end else if (d >= 4'd5) begin
      res = (pos == 2'd0) ? KIND_FIVE : KIND_UNIT;
    end
    return res;
  endfunction

  function automatic logic [SymbolWidth-1:0] place_letter(logic [1:0] place,
                                                          letter_kind_e kind);
    logic [SymbolWidth-1:0] res;
    res = CHAR_M;
    unique case (place)
      PLACE_THOUSANDS: res = CHAR_M;
      PLACE_HUNDREDS: begin
        case (kind)
          KIND_FIVE: res = CHAR_D;
          KIND_TEN:  res = CHAR_M;
          default:   res = CHAR_C;
        endcase
      end
      PLACE_TENS: begin
        case (kind)
          KIND_FIVE: res = CHAR_L;
          KIND_TEN:  res = CHAR_C;
          default:   res = CHAR_X;
        endcase
      end
      default: begin
        case (kind)
          KIND_FIVE: res = CHAR_V;
          KIND_TEN:  res = CHAR_X;
          default:   res = CHAR_I;
        endcase
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/itrn_datapath.sv
// Datapath: decimal digit split, digit store and letter output registers
`default_nettype none

module itrn_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire itrn_pkg::ctl_cmd_t                   cmd_i,
  input  wire logic [itrn_pkg::ValueWidth-1:0]      value_i,
  output itrn_pkg::dp_status_t                      status_o,
  output logic                                      strobe_o,
  output logic [itrn_pkg::SymbolWidth-1:0]          symbol_o,
  output logic                                      last_o
);

  logic [itrn_pkg::ValueWidth-1:0]  rem_q, rem_d;
  logic [itrn_pkg::DigitWidth-1:0]  digit_q [4];
  logic [itrn_pkg::DigitWidth-1:0]  split_digit;
  logic [itrn_pkg::ThrWidth-1:0]    split_sub;
  logic [itrn_pkg::DigitWidth-1:0]  cur_digit;
  itrn_pkg::letter_kind_e           cur_kind;
  logic [itrn_pkg::SymbolWidth-1:0] cur_symbol;
  logic                             cur_last;
  logic                             strobe_q;
  logic [itrn_pkg::SymbolWidth-1:0] symbol_q;
  logic                             last_q;

  // Digit of the current place: largest k with k*weight <= remainder
  always_comb begin
    logic [itrn_pkg::ThrWidth-1:0] thr;
    split_digit = '0;
    split_sub   = '0;
    for (int k = 1; k < 10; k++) begin
      thr = itrn_pkg::place_threshold(cmd_i.place, itrn_pkg::DigitWidth'(k));
      if ({2'b00, rem_q} >= thr) begin
        split_digit = itrn_pkg::DigitWidth'(k);
        split_sub   = thr;
      end
    end
    rem_d = rem_q - split_sub[itrn_pkg::ValueWidth-1:0];
  end

  assign cur_digit  = digit_q[cmd_i.place];
  assign cur_kind   = itrn_pkg::digit_kind(cur_digit, cmd_i.pos);
  assign cur_symbol = itrn_pkg::place_letter(cmd_i.place, cur_kind);

  always_comb begin
    status_o.len = itrn_pkg::digit_len(cur_digit);
    unique case (cmd_i.place)
      itrn_pkg::PLACE_THOUSANDS:
        status_o.tail_zero = (digit_q[2] == '0) && (digit_q[1] == '0) && (digit_q[0] == '0);
      itrn_pkg::PLACE_HUNDREDS:
        status_o.tail_zero = (digit_q[1] == '0) && (digit_q[0] == '0);
      itrn_pkg::PLACE_TENS:
        status_o.tail_zero = (digit_q[0] == '0);
      default:
        status_o.tail_zero = 1'b1;
    endcase
  end

  assign cur_last = (({1'b0, cmd_i.pos} + 3'd1) == status_o.len) && status_o.tail_zero;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= value_i;
    end else if (cmd_i.split) begin
      rem_q <= rem_d;
    end
    if (cmd_i.split) begin
      // thousands digit above 3 gives no M letters
      if (cmd_i.place == itrn_pkg::PLACE_THOUSANDS && split_digit > 4'd3) begin
        digit_q[cmd_i.place] <= '0;
      end else begin
        digit_q[cmd_i.place] <= split_digit;
      end
    end
    if (cmd_i.emit) begin
      symbol_q <= cur_symbol;
      last_q   <= cur_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  assign strobe_o = strobe_q;
  assign symbol_o = symbol_q;
  assign last_o   = last_q;

endmodule

`default_nettype wire

### rtl/core/itrn_ctrl.sv
// Controller: sequences load, digit split and letter emission per item
`default_nettype none

module itrn_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire itrn_pkg::dp_status_t status_i,
  output itrn_pkg::ctl_cmd_t        cmd_o,
  output logic                      busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] place_q, place_d;
  logic [1:0] pos_q, pos_d;
  logic       busy_q, busy_d;

  always_comb begin
    state_d     = state_q;
    place_d     = place_q;
    pos_d       = pos_q;
    cmd_o       = '0;
    cmd_o.place = place_q;
    cmd_o.pos   = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SPLIT;
          place_d    = itrn_pkg::PLACE_THOUSANDS;
        end
      end
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
        if (place_q == itrn_pkg::PLACE_ONES) begin
          state_d = ST_EMIT;
          place_d = itrn_pkg::PLACE_THOUSANDS;
          pos_d   = '0;
        end else begin
          place_d = place_q - 2'd1;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = (status_i.len != 3'd0);
        // an empty digit still takes an emit step, with no letter
        if (({1'b0, pos_q} + 3'd1) >= status_i.len) begin
          pos_d = '0;
          if (place_q == itrn_pkg::PLACE_ONES) begin
            state_d = ST_IDLE;
          end else begin
            place_d = place_q - 2'd1;
          end
        end else begin
          pos_d = pos_q + 2'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    busy_d = (state_d != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      place_q <= itrn_pkg::PLACE_THOUSANDS;
      pos_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      place_q <= place_d;
      pos_q   <= pos_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

### rtl/core/integer_to_roman_numeral.sv
// Top level: integer to Roman numeral converter, controller plus datapath
// The controller walks four split steps, then one emit step per letter or empty place.
// A new item is taken only in idle, once the last emit step of the previous one is done;
//   letters come one per cycle but for a gap at each empty place; the receiver cannot stall.
// Reset is asynchronous, active low, and returns the controller to idle with no strobe.
`default_nettype none

module integer_to_roman_numeral (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic [itrn_pkg::ValueWidth-1:0]      value_i,
  output logic                                      busy_o,
  output logic                                      strobe_o,
  output logic [itrn_pkg::SymbolWidth-1:0]          symbol_o,
  output logic                                      last_o
);

  itrn_pkg::ctl_cmd_t   cmd;
  itrn_pkg::dp_status_t status;

  itrn_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  itrn_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .value_i  (value_i),
    .status_o (status),
    .strobe_o (strobe_o),
    .symbol_o (symbol_o),
    .last_o   (last_o)
  );

endmodule

`default_nettype wire

### rtl/core/itrn_checker.sv
// Checker: port-level assertions for the Roman numeral converter, bound to the top level
`default_nettype none

module itrn_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 start_i,
  input wire logic                                 busy_o,
  input wire logic                                 strobe_o,
  input wire logic [itrn_pkg::SymbolWidth-1:0]     symbol_o,
  input wire logic                                 last_o
);

  // An accepted item makes the block busy as its split steps begin
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o ##1 busy_o)
    else $error("busy not held after item accepted");

  // Busy only rises from an accepted item
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without start");

  // A letter that is not the last one means more letters follow
  a_more_letters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> busy_o)
    else $error("non-final letter while idle");

  a_letter_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (symbol_o == itrn_pkg::CHAR_I || symbol_o == itrn_pkg::CHAR_V ||
                  symbol_o == itrn_pkg::CHAR_X || symbol_o == itrn_pkg::CHAR_L ||
                  symbol_o == itrn_pkg::CHAR_C || symbol_o == itrn_pkg::CHAR_D ||
                  symbol_o == itrn_pkg::CHAR_M))
    else $error("strobe with a code that is no numeral letter");

endmodule

bind integer_to_roman_numeral itrn_checker u_itrn_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .strobe_o (strobe_o),
  .symbol_o (symbol_o),
  .last_o   (last_o)
);

`default_nettype wire

### tb/sv/tb_integer_to_roman_numeral.sv
// Testbench: integer to Roman numeral converter, letters checked against a local predictor
module tb_integer_to_roman_numeral;

  localparam int ValueWidth  = itrn_pkg::ValueWidth;
  localparam int SymbolWidth = itrn_pkg::SymbolWidth;

  typedef struct {
    logic [ValueWidth-1:0] value;
    int unsigned           gap;
    bit                    drain;
  } conv_req_t;

  typedef struct {
    logic [SymbolWidth-1:0] symbol;
    logic                   last;
  } letter_t;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   start_i = 1'b0;
  logic [ValueWidth-1:0]  value_i = '0;
  logic                   busy_o;
  logic                   strobe_o;
  logic [SymbolWidth-1:0] symbol_o;
  logic                   last_o;

  conv_req_t   conv_reqs[$];
  letter_t     letters_due[$];
  int unsigned idle_left = 0;
  int unsigned errors    = 0;

  integer_to_roman_numeral dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .value_i (value_i),
    .busy_o  (busy_o),
    .strobe_o(strobe_o),
    .symbol_o(symbol_o),
    .last_o  (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_letter(logic [SymbolWidth-1:0] sym);
    letter_t l;
    l.symbol = sym;
    l.last   = 1'b0;
    letters_due.push_back(l);
  endfunction

  function automatic void push_digit(int unsigned d, logic [SymbolWidth-1:0] one,
                                     logic [SymbolWidth-1:0] five,
                                     logic [SymbolWidth-1:0] ten);
    if (d == 9) begin
      push_letter(one);
      push_letter(ten);
    end else if (d == 4) begin
      push_letter(one);
      push_letter(five);
    end else if (d >= 5) begin
      push_letter(five);
      for (int unsigned k = 5; k < d; k++) push_letter(one);
    end else begin
      for (int unsigned k = 0; k < d; k++) push_letter(one);
    end
  endfunction

  // Expected letters of one value; thousands digit 4 gives no M
  function automatic void predict_numeral(logic [ValueWidth-1:0] value);
    int unsigned v;
    int unsigned before_cnt;
    v = value;
    before_cnt = letters_due.size();
    if (v / 1000 <= 3) begin
      for (int unsigned k = 0; k < v / 1000; k++) push_letter(itrn_pkg::CHAR_M);
    end
    push_digit((v / 100) % 10, itrn_pkg::CHAR_C, itrn_pkg::CHAR_D, itrn_pkg::CHAR_M);
    push_digit((v / 10) % 10, itrn_pkg::CHAR_X, itrn_pkg::CHAR_L, itrn_pkg::CHAR_C);
    push_digit(v % 10, itrn_pkg::CHAR_I, itrn_pkg::CHAR_V, itrn_pkg::CHAR_X);
    if (letters_due.size() > before_cnt) letters_due[letters_due.size()-1].last = 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_req(logic [ValueWidth-1:0] value, int unsigned gap, bit drain);
    conv_req_t q;
    q.value = value;
    q.gap   = gap;
    q.drain = drain;
    conv_reqs.push_back(q);
  endfunction

  always @(posedge clk_i) begin : drive
    conv_req_t q;
    if (!rst_ni) begin
      start_i <= 1'b0;
      value_i <= '0;
    end else begin
      if (start_i && !busy_o) predict_numeral(value_i);
      if (!(start_i && busy_o)) begin
        if (idle_left > 0) begin
          idle_left--;
          start_i <= 1'b0;
          value_i <= ValueWidth'($urandom);
        end else if (conv_reqs.size() > 0 && conv_reqs[0].gap > 0) begin
          idle_left = conv_reqs[0].gap - 1;
          conv_reqs[0].gap = 0;
          start_i <= 1'b0;
          value_i <= ValueWidth'($urandom);
        end else if (conv_reqs.size() > 0 &&
                     (!conv_reqs[0].drain || letters_due.size() == 0)) begin
          q = conv_reqs.pop_front();
          start_i <= 1'b1;
          value_i <= q.value;
        end else begin
          start_i <= 1'b0;
          value_i <= ValueWidth'($urandom);
        end
      end
    end
  end

  // Outputs change only at rising edges, so mid-cycle sampling sees the settled letter
  always @(negedge clk_i) begin : monitor
    letter_t want;
    if (rst_ni && strobe_o) begin
      if (letters_due.size() == 0) begin
        $display("%0t: unexpected letter, actual symbol %h last %b", $time, symbol_o, last_o);
        errors++;
      end else begin
        want = letters_due.pop_front();
        if (symbol_o !== want.symbol) begin
          $display("%0t: symbol mismatch, expected %h actual %h", $time, want.symbol, symbol_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last mismatch, expected %b actual %b", $time, want.last, last_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [ValueWidth-1:0] directed[$];
    int unsigned           burst_left;
    int unsigned           r;
    logic [ValueWidth-1:0] v;
    directed = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd49, 12'd90,
                 12'd99, 12'd400, 12'd444, 12'd900, 12'd999, 12'd1000, 12'd3000,
                 12'd3494, 12'd3888, 12'd3999, 12'd4000, 12'd4001, 12'd4095,
                 12'd2048, 12'h555, 12'hAAA};
    burst_left = 0;
    foreach (directed[i]) add_req(directed[i], pick_gap(), 1'b0);
    // hold off until the directed letters are all out
    add_req(12'd1994, 0, 1'b1);
    for (int i = 0; i < 354; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) v = ValueWidth'($urandom_range(4000, 4095));
      else if (r < 25) v = ValueWidth'($urandom_range(0, 99));
      else if (r < 40) v = ValueWidth'($urandom_range(3000, 3999));
      else v = ValueWidth'($urandom);
      if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 25);
      if (burst_left > 0) begin
        burst_left--;
        add_req(v, 0, 1'b0);
      end else begin
        add_req(v, pick_gap(), $urandom_range(0, 39) == 0);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(conv_reqs.size() == 0 && !start_i && letters_due.size() == 0)) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (letters_due.size() != 0) begin
      $display("%0t: %0d expected letters never came", $time, letters_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS integer_to_roman_numeral");
    end else begin
      $display("FAIL integer_to_roman_numeral");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL integer_to_roman_numeral");
    $finish;
  end

endmodule

### sim.f
rtl/core/itrn_pkg.sv
rtl/core/itrn_datapath.sv
rtl/core/itrn_ctrl.sv
rtl/core/integer_to_roman_numeral.sv
rtl/core/itrn_checker.sv
tb/sv/tb_integer_to_roman_numeral.sv
